// ----- rtl/mwr_pkg.sv -----
// ----------------------------------------------------------------------------
// mwr_pkg: shared types, codes and helpers
// Item and result codes, frame constants and the byte-wide CRC16 step used
// by the write-register master.
// ----------------------------------------------------------------------------
package mwr_pkg;

  // receive buffer size and counter width
  localparam int unsigned RxBufferBytes = 256;
  localparam int unsigned RxCntW        = $clog2(RxBufferBytes + 1);
  localparam int unsigned MinReplyBytes = 8;

  // input item kinds
  localparam logic [1:0] KindStart  = 2'd0;
  localparam logic [1:0] KindByte   = 2'd1;
  localparam logic [1:0] KindWinEnd = 2'd2;

  // result kinds
  localparam logic OutTx     = 1'b0;
  localparam logic OutStatus = 1'b1;

  // status codes
  localparam logic [1:0] StSuccess  = 2'd0;
  localparam logic [1:0] StCrcRetry = 2'd1;
  localparam logic [1:0] StNoResp   = 2'd2;
  localparam logic [1:0] StFailed   = 2'd3;

  // frame constants
  localparam logic [7:0]  FuncWriteSingle = 8'h06;
  localparam logic [15:0] CrcInit         = 16'hFFFF;
  localparam logic [15:0] CrcPoly         = 16'hA001;
  localparam int unsigned FrameBytes      = 8;
  localparam int unsigned FramePosW       = $clog2(FrameBytes + 1);

  // one transmit run handed from the transaction control to the frame builder
  typedef struct packed {
    logic        has_status;
    logic        has_frame;
    logic [1:0]  status;
    logic [3:0]  attempt;
    logic [7:0]  slave;
    logic [15:0] address;
    logic [15:0] value;
  } run_desc_t;

  // reflected crc16 over one byte, bit by bit
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CrcPoly;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

// ----- rtl/mwr_if.sv -----
// ----------------------------------------------------------------------------
// mwr_in_if / mwr_out_if: channel interfaces
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface mwr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] register_address;
  logic [15:0] register_value;
  logic [7:0]  rx_byte;

  modport source(output valid, output kind, output register_address,
                 output register_value, output rx_byte, input ready);
  modport sink(input valid, input kind, input register_address,
               input register_value, input rx_byte, output ready);
endinterface

interface mwr_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] tx_byte;
  logic       last_of_run;
  logic [1:0] status;
  logic [3:0] attempt_number;

  modport source(output valid, output out_kind, output tx_byte,
                 output last_of_run, output status, output attempt_number,
                 input ready);
  modport sink(input valid, input out_kind, input tx_byte, input last_of_run,
               input status, input attempt_number, output ready);
endinterface

// ----- rtl/mwr_txn_ctrl.sv -----
// ----------------------------------------------------------------------------
// mwr_txn_ctrl: transaction control
// Holds the input register, configuration and transaction state; decides
// on each item and hands transmit runs to the frame builder.
// ----------------------------------------------------------------------------
module mwr_txn_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [7:0]             cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_kind,
  input  logic [15:0]            in_address,
  input  logic [15:0]            in_value,
  input  logic [7:0]             in_rx_byte,
  input  logic                   gen_busy,
  output logic                   run_valid,
  output mwr_pkg::run_desc_t     run_desc
);

  localparam logic CfgSlave = 1'b0;
  localparam logic CfgRetry = 1'b1;

  logic [7:0]  slave_address_r;
  logic [3:0]  retry_limit_r;

  logic        item_valid_r;
  logic [1:0]  kind_r;
  logic [15:0] item_address_r;
  logic [15:0] item_value_r;
  logic [7:0]  item_byte_r;

  logic                      busy_r, busy_nxt;
  logic [15:0]               saved_address_r, saved_address_nxt;
  logic [15:0]               saved_value_r, saved_value_nxt;
  logic [3:0]                attempts_r, attempts_nxt;
  logic [mwr_pkg::RxCntW-1:0] rx_count_r, rx_count_nxt;
  logic [15:0]               rx_crc_r, rx_crc_nxt;

  logic       needs_gen;
  logic       proc_fire;
  logic [3:0] limit;
  logic       long_enough;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r <= 8'd1;
      retry_limit_r   <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgSlave: slave_address_r <= cfg_wdata;
        CfgRetry: retry_limit_r   <= cfg_wdata[3:0];
        default:  slave_address_r <= slave_address_r;
      endcase
    end
  end

  // item leaves the input register once the frame builder can take its run
  assign needs_gen = (kind_r == mwr_pkg::KindStart) || (kind_r == mwr_pkg::KindWinEnd);
  assign proc_fire = item_valid_r && !(needs_gen && gen_busy);
  assign in_ready  = !item_valid_r || proc_fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      kind_r         <= in_kind;
      item_address_r <= in_address;
      item_value_r   <= in_value;
      item_byte_r    <= in_rx_byte;
    end
  end

  assign limit       = (retry_limit_r == 4'd0) ? 4'd1 : retry_limit_r;
  assign long_enough = rx_count_r >= mwr_pkg::RxCntW'(mwr_pkg::MinReplyBytes);

  // per-item decision
  always_comb begin
    busy_nxt          = busy_r;
    saved_address_nxt = saved_address_r;
    saved_value_nxt   = saved_value_r;
    attempts_nxt      = attempts_r;
    rx_count_nxt      = rx_count_r;
    rx_crc_nxt        = rx_crc_r;
    run_valid         = 1'b0;
    run_desc.has_status = 1'b0;
    run_desc.has_frame  = 1'b0;
    run_desc.status     = mwr_pkg::StSuccess;
    run_desc.attempt    = attempts_r;
    run_desc.slave      = slave_address_r;
    run_desc.address    = saved_address_r;
    run_desc.value      = saved_value_r;
    if (proc_fire) begin
      unique case (kind_r)
        mwr_pkg::KindStart: begin
          saved_address_nxt  = item_address_r;
          saved_value_nxt    = item_value_r;
          busy_nxt           = 1'b1;
          attempts_nxt       = 4'd1;
          rx_count_nxt       = '0;
          rx_crc_nxt         = mwr_pkg::CrcInit;
          run_valid          = 1'b1;
          run_desc.has_frame = 1'b1;
          run_desc.address   = item_address_r;
          run_desc.value     = item_value_r;
        end
        mwr_pkg::KindByte: begin
          if (busy_r && (rx_count_r < mwr_pkg::RxCntW'(mwr_pkg::RxBufferBytes))) begin
            rx_crc_nxt   = mwr_pkg::crc_byte(rx_crc_r, item_byte_r);
            rx_count_nxt = rx_count_r + 1'b1;
          end
        end
        mwr_pkg::KindWinEnd: begin
          if (busy_r) begin
            run_valid           = 1'b1;
            run_desc.has_status = 1'b1;
            if (long_enough && (rx_crc_r == 16'h0000)) begin
              run_desc.status = mwr_pkg::StSuccess;
              busy_nxt        = 1'b0;
            end else if (attempts_r >= limit) begin
              run_desc.status = mwr_pkg::StFailed;
              busy_nxt        = 1'b0;
            end else begin
              run_desc.status    = long_enough ? mwr_pkg::StCrcRetry : mwr_pkg::StNoResp;
              run_desc.has_frame = 1'b1;
              attempts_nxt       = attempts_r + 4'd1;
              rx_count_nxt       = '0;
              rx_crc_nxt         = mwr_pkg::CrcInit;
            end
          end
        end
        default: begin
          busy_nxt = busy_r;
        end
      endcase
    end
  end

  // transaction state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r          <= 1'b0;
      saved_address_r <= '0;
      saved_value_r   <= '0;
      attempts_r      <= '0;
      rx_count_r      <= '0;
      rx_crc_r        <= mwr_pkg::CrcInit;
    end else begin
      busy_r          <= busy_nxt;
      saved_address_r <= saved_address_nxt;
      saved_value_r   <= saved_value_nxt;
      attempts_r      <= attempts_nxt;
      rx_count_r      <= rx_count_nxt;
      rx_crc_r        <= rx_crc_nxt;
    end
  end

endmodule

// ----- rtl/mwr_frame_gen.sv -----
// ----------------------------------------------------------------------------
// mwr_frame_gen: frame builder and result register
// Plays out one run (optional status beat, optional 8-byte frame) one beat
// per cycle unless stalled, folding in the frame CRC as header bytes go out.
// ----------------------------------------------------------------------------
module mwr_frame_gen (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               run_valid,
  input  mwr_pkg::run_desc_t run_desc,
  output logic               gen_busy,
  mwr_out_if.source          out_ch
);

  logic                          active_r, active_nxt;
  mwr_pkg::run_desc_t            desc_r;
  logic [mwr_pkg::FramePosW-1:0] pos_r, pos_nxt;
  logic [15:0]                   crc_r, crc_nxt;

  logic       out_valid_r;
  logic       out_kind_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [1:0] out_status_r;
  logic [3:0] out_attempt_r;

  logic       step;
  logic [2:0] byte_idx;
  logic [7:0] frame_byte;
  logic       beat_kind;
  logic [7:0] beat_byte;
  logic       beat_last;
  logic [1:0] beat_status;
  logic [3:0] beat_attempt;

  assign gen_busy = active_r;
  assign step     = active_r && (!out_valid_r || out_ch.ready);

  // frame byte select, position 0 holds the status beat
  assign byte_idx = 3'(pos_r - 1'b1);

  always_comb begin
    unique case (byte_idx)
      3'd0:    frame_byte = desc_r.slave;
      3'd1:    frame_byte = mwr_pkg::FuncWriteSingle;
      3'd2:    frame_byte = desc_r.address[15:8];
      3'd3:    frame_byte = desc_r.address[7:0];
      3'd4:    frame_byte = desc_r.value[15:8];
      3'd5:    frame_byte = desc_r.value[7:0];
      3'd6:    frame_byte = crc_r[7:0];
      default: frame_byte = crc_r[15:8];
    endcase
  end

  // beat contents and run sequencing
  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    if (pos_r == '0) begin
      beat_kind    = mwr_pkg::OutStatus;
      beat_byte    = 8'h00;
      beat_last    = !desc_r.has_frame;
      beat_status  = desc_r.status;
      beat_attempt = desc_r.attempt;
    end else begin
      beat_kind    = mwr_pkg::OutTx;
      beat_byte    = frame_byte;
      beat_last    = pos_r == mwr_pkg::FramePosW'(mwr_pkg::FrameBytes);
      beat_status  = mwr_pkg::StSuccess;
      beat_attempt = 4'd0;
    end
    if (step) begin
      if (pos_r != '0 && byte_idx < 3'd6) begin
        crc_nxt = mwr_pkg::crc_byte(crc_r, frame_byte);
      end
      if (beat_last) active_nxt = 1'b0;
      else           pos_nxt    = pos_r + 1'b1;
    end else if (run_valid && !active_r) begin
      active_nxt = 1'b1;
      pos_nxt    = run_desc.has_status ? '0 : mwr_pkg::FramePosW'(1);
      crc_nxt    = mwr_pkg::CrcInit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    crc_r <= crc_nxt;
    if (run_valid && !active_r) desc_r <= run_desc;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_kind_r    <= beat_kind;
      out_byte_r    <= beat_byte;
      out_last_r    <= beat_last;
      out_status_r  <= beat_status;
      out_attempt_r <= beat_attempt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_kind       = out_kind_r;
  assign out_ch.tx_byte        = out_byte_r;
  assign out_ch.last_of_run    = out_last_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.attempt_number = out_attempt_r;

endmodule

// ----- rtl/modbus_write_register_master_unit.sv -----
// ----------------------------------------------------------------------------
// modbus_write_register_master_unit: Modbus RTU write-single-register master
// Builds request frames, checks replies by CRC residual and retries.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : items in (start write, received byte, response window end).
//   out_ch : result beats out (status report first, then frame bytes).
//   cfg_*  : register writes, index 0 slave address, index 1 retry limit;
//            write only while the block is idle.
// Path: an item is decided from the input register, its run is loaded
//   into the frame builder, and its first beat goes to the output register.
// Throughput: received bytes are taken one per cycle unless a start or
//   window end waits in the input register; the receive CRC is one
//   byte-wide update per cycle. A start or a retry plays out through the
//   frame builder one beat per cycle while out_ch.ready allows (8 or 9
//   beats); the next start or window end waits until that run is done.
// Reset: synchronous active-low rst_n; block idle, slave address 1,
//   retry limit 3, no beat pending.
// Stall: when out_ch.ready is low the result beat holds, the frame builder
//   stops, and in_ch.ready drops once a start or window end is held.
// ----------------------------------------------------------------------------
module modbus_write_register_master_unit (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [7:0] cfg_wdata,
  mwr_in_if.sink    in_ch,
  mwr_out_if.source out_ch
);

  logic               gen_busy;
  logic               run_valid;
  mwr_pkg::run_desc_t run_desc;

  mwr_txn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_kind    (in_ch.kind),
    .in_address (in_ch.register_address),
    .in_value   (in_ch.register_value),
    .in_rx_byte (in_ch.rx_byte),
    .gen_busy   (gen_busy),
    .run_valid  (run_valid),
    .run_desc   (run_desc)
  );

  mwr_frame_gen u_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .run_valid (run_valid),
    .run_desc  (run_desc),
    .gen_busy  (gen_busy),
    .out_ch    (out_ch)
  );

  // a new run is only handed over to an idle frame builder
  a_run_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid |-> !gen_busy)
    else $error("run handed to busy frame builder");

  // status beats carry no frame byte
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_kind == mwr_pkg::OutStatus) |-> out_ch.tx_byte == 8'h00)
    else $error("status beat with frame byte");

  // frame beats carry no status and no attempt number
  a_tx_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_kind == mwr_pkg::OutTx) |->
      (out_ch.status == mwr_pkg::StSuccess && out_ch.attempt_number == 4'd0))
    else $error("frame beat with status fields");

  // a run that carries a status report always has a nonzero attempt number
  a_attempt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (run_valid && run_desc.has_status) |-> run_desc.attempt != 4'd0)
    else $error("status for attempt zero");

endmodule

// ----- sim/mwr_result_checker.sv -----
// ----------------------------------------------------------------------------
// mwr_result_checker: write-register master result checker
// Watches the config port and both channels, keeps its own copy of the
// transaction state, works out the frame and status beats that every
// accepted item should cause, and compares them with the result beats.
// ----------------------------------------------------------------------------
module mwr_result_checker #(
  parameter logic RegSlaveAddr  = 1'b0,
  parameter logic RegRetryLimit = 1'b1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  mwr_in_if           in_mon,
  mwr_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned pending_beats
);
  import mwr_pkg::*;

  localparam logic [7:0] SlaveAddrReset  = 8'd1;
  localparam logic [3:0] RetryLimitReset = 4'd3;

  typedef struct packed {
    logic       okind;
    logic [7:0] tx;
    logic       last;
    logic [1:0] st;
    logic [3:0] att;
  } result_beat_t;

  // register shadows
  logic [7:0] slave_reg;
  logic [3:0] retry_reg;

  // transaction state
  logic              xact_open;
  logic [15:0]       req_addr;
  logic [15:0]       req_value;
  logic [3:0]        attempt_cnt;
  logic [RxCntW-1:0] rx_len;
  logic [15:0]       rx_crc_acc;

  result_beat_t expected_beats[$];
  result_beat_t got;
  result_beat_t want;

  // modbus crc16, one byte, lsb first
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ b[k];
      r  = r >> 1;
      if (fb) r = r ^ CrcPoly;
    end
    return r;
  endfunction

  // request frame from the current slave address, then clear the receive side
  task automatic queue_frame();
    logic [7:0]  frame[FrameBytes];
    logic [15:0] crc;
    frame[0] = slave_reg;
    frame[1] = FuncWriteSingle;
    frame[2] = req_addr[15:8];
    frame[3] = req_addr[7:0];
    frame[4] = req_value[15:8];
    frame[5] = req_value[7:0];
    crc = CrcInit;
    for (int i = 0; i < 6; i++) crc = crc16_step(crc, frame[i]);
    frame[6] = crc[7:0];
    frame[7] = crc[15:8];
    for (int i = 0; i < FrameBytes; i++) begin
      expected_beats.push_back('{okind: OutTx, tx: frame[i], last: (i == FrameBytes - 1),
                                 st: 2'b00, att: 4'd0});
    end
    rx_len     = '0;
    rx_crc_acc = CrcInit;
  endtask

  task automatic queue_status(input logic [1:0] st, input logic last);
    expected_beats.push_back('{okind: OutStatus, tx: 8'h00, last: last, st: st,
                               att: attempt_cnt});
  endtask

  // expected beats for one accepted item
  task automatic predict_item(input logic [1:0] kind, input logic [15:0] addr,
                              input logic [15:0] val, input logic [7:0] rxb);
    logic [3:0] eff_limit;
    logic [1:0] verdict;
    eff_limit = (retry_reg == 4'd0) ? 4'd1 : retry_reg;
    case (kind)
      KindStart: begin
        // a start while busy just drops the old transaction
        req_addr    = addr;
        req_value   = val;
        xact_open   = 1'b1;
        attempt_cnt = 4'd1;
        queue_frame();
      end
      KindByte: begin
        // saturating receive buffer
        if (xact_open && rx_len < RxBufferBytes) begin
          rx_crc_acc = crc16_step(rx_crc_acc, rxb);
          rx_len     = rx_len + 1'b1;
        end
      end
      KindWinEnd: begin
        if (xact_open) begin
          if (rx_len >= MinReplyBytes && rx_crc_acc == 16'h0000) begin
            queue_status(StSuccess, 1'b1);
            xact_open = 1'b0;
          end else begin
            verdict = (rx_len >= MinReplyBytes) ? StCrcRetry : StNoResp;
            if (attempt_cnt >= eff_limit) begin
              queue_status(StFailed, 1'b1);
              xact_open = 1'b0;
            end else begin
              queue_status(verdict, 1'b0);
              attempt_cnt = attempt_cnt + 4'd1;
              queue_frame();
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // sample everything at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      slave_reg   = SlaveAddrReset;
      retry_reg   = RetryLimitReset;
      xact_open   = 1'b0;
      req_addr    = '0;
      req_value   = '0;
      attempt_cnt = '0;
      rx_len      = '0;
      rx_crc_acc  = CrcInit;
      fail_count  = 0;
      expected_beats.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == RegSlaveAddr) slave_reg = cfg_wdata;
        else if (cfg_index == RegRetryLimit) retry_reg = cfg_wdata[3:0];
      end

      // result beat first: an item never causes a beat on its own edge
      if (out_mon.valid && out_mon.ready) begin
        got = '{okind: out_mon.out_kind, tx: out_mon.tx_byte, last: out_mon.last_of_run,
                st: out_mon.status, att: out_mon.attempt_number};
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat: kind %0d tx %02h last %0d status %0d att %0d",
                   $time, got.okind, got.tx, got.last, got.st, got.att);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (got.okind !== want.okind || got.tx !== want.tx || got.last !== want.last ||
              got.st !== want.st || got.att !== want.att) begin
            $display("%0t: result mismatch: expected kind %0d tx %02h last %0d status %0d att %0d",
                     $time, want.okind, want.tx, want.last, want.st, want.att);
            $display("%0t:                   actual kind %0d tx %02h last %0d status %0d att %0d",
                     $time, got.okind, got.tx, got.last, got.st, got.att);
            fail_count++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        predict_item(in_mon.kind, in_mon.register_address, in_mon.register_value,
                     in_mon.rx_byte);
      end
    end
    pending_beats <= expected_beats.size();
  end

endmodule

// ----- sim/tb_modbus_write_register_master_unit.sv -----
// ----------------------------------------------------------------------------
// tb_modbus_write_register_master_unit: write-register master testbench
// Drives start, receive-byte and window-end items in random bursts against a
// stalling receiver, sweeps slave address and retry limit between phases,
// and leaves all prediction and comparison to the result checker.
// ----------------------------------------------------------------------------
module tb_modbus_write_register_master_unit;
  import mwr_pkg::*;

  localparam logic       RegSlaveAddr   = 1'b0;
  localparam logic       RegRetryLimit  = 1'b1;
  localparam logic [1:0] KindUnused     = 2'd3;
  localparam int         RandomItems    = 60;
  localparam int         NumPhases      = 6;
  localparam int         SettleCycles   = 8;
  localparam int         HoldCycles     = 120;
  localparam int         WatchdogCycles = 3000;

  typedef enum logic [2:0] {
    ReplyEcho, ReplyLong, ReplyBadCrc, ReplyShort, ReplyNone, ReplyGarbage
  } reply_t;

  typedef enum logic [1:0] {RdyAlways, RdyCoin, RdyMostly, RdyBursty} rdy_mode_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_wdata;

  mwr_in_if  in_ch();
  mwr_out_if out_ch();

  int unsigned fail_count;
  int unsigned pending_beats;
  int unsigned burst_left;
  int unsigned counted_items;
  int unsigned hold_requests;
  int unsigned idle_cycles;
  logic [7:0]  cur_slave;
  logic [3:0]  cur_retry;
  logic [7:0]  reply_q[$];

  modbus_write_register_master_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  mwr_result_checker #(
    .RegSlaveAddr (RegSlaveAddr),
    .RegRetryLimit(RegRetryLimit)
  ) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .pending_beats(pending_beats)
  );

  always #6 clk = ~clk;

  // one input beat, with bursts and gaps on the sender side
  task automatic send_beat(input logic [1:0] kind, input logic [15:0] addr,
                           input logic [15:0] val, input logic [7:0] rxb, input bit counted);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    in_ch.valid            <= 1'b1;
    in_ch.kind             <= kind;
    in_ch.register_address <= addr;
    in_ch.register_value   <= val;
    in_ch.rx_byte          <= rxb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    if (counted) counted_items++;
  endtask

  task automatic send_start(input logic [15:0] addr, input logic [15:0] val);
    send_beat(KindStart, addr, val, 8'($urandom), 1'b1);
  endtask

  task automatic send_rx(input logic [7:0] b);
    send_beat(KindByte, 16'($urandom), 16'($urandom), b, 1'b1);
  endtask

  task automatic send_win_end();
    send_beat(KindWinEnd, 16'($urandom), 16'($urandom), 8'($urandom), 1'b1);
  endtask

  // stop offering and wait until every expected beat is out
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] slave, input logic [3:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= RegSlaveAddr;
    cfg_wdata <= slave;
    @(posedge clk);
    cfg_index <= RegRetryLimit;
    cfg_wdata <= {4'($urandom), limit};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_slave = slave;
    cur_retry = limit;
  endtask

  // extremes now and then, random otherwise
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // slave reply bytes for one attempt
  task automatic build_reply(input reply_t mode, input logic [15:0] addr, input logic [15:0] val);
    logic [15:0] crc;
    bit          seal;
    int unsigned n;
    int unsigned pos;
    reply_q.delete();
    seal = 1'b0;
    case (mode)
      ReplyEcho, ReplyBadCrc: begin
        reply_q = '{cur_slave, FuncWriteSingle, addr[15:8], addr[7:0], val[15:8], val[7:0]};
        seal = 1'b1;
      end
      ReplyLong: begin
        n = $urandom_range(6, 24);
        repeat (n) reply_q.push_back(8'($urandom));
        seal = 1'b1;
      end
      ReplyShort: begin
        // under eight bytes, sometimes with a good crc
        if ($urandom_range(0, 1) == 0) begin
          n = $urandom_range(0, 5);
          seal = 1'b1;
        end else begin
          n = $urandom_range(1, 7);
        end
        repeat (n) reply_q.push_back(8'($urandom));
      end
      ReplyGarbage: begin
        n = $urandom_range(8, 16);
        repeat (n) reply_q.push_back(8'($urandom));
      end
      default: ;
    endcase
    if (seal) begin
      crc = CrcInit;
      foreach (reply_q[i]) crc = crc_byte(crc, reply_q[i]);
      reply_q.push_back(crc[7:0]);
      reply_q.push_back(crc[15:8]);
    end
    // single bit flip always breaks the crc
    if (mode == ReplyBadCrc) begin
      pos = $urandom_range(0, reply_q.size() - 1);
      reply_q[pos] = reply_q[pos] ^ 8'(1 << $urandom_range(0, 7));
    end
  endtask

  // receiver: stall pattern of its own plus one long hold-off on request
  initial begin
    rdy_mode_t   mode;
    int unsigned mode_left;
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned holds_done;
    logic        rdy;
    out_ch.ready <= 1'b0;
    mode       = RdyAlways;
    mode_left  = 0;
    stall_left = 0;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        hold_left  = HoldCycles;
        holds_done = hold_requests;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rdy_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RdyAlways: rdy = 1'b1;
          RdyCoin:   rdy = 1'($urandom_range(0, 1));
          RdyMostly: rdy = ($urandom_range(0, 4) != 0);
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              rdy = 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
              stall_left = $urandom_range(1, 10);
              rdy = 1'b0;
            end else begin
              rdy = 1'b1;
            end
          end
        endcase
      end
      out_ch.ready <= rdy;
    end
  end

  // watchdog on beats moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogCycles) begin
        $display("%0t: watchdog, no beat moved for %0d cycles", $time, idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [7:0]  phase_slave[NumPhases];
    logic [3:0]  phase_retry[NumPhases];
    logic [15:0] addr;
    logic [15:0] val;
    logic [3:0]  limit;
    reply_t      mode;
    bit          abandoned;
    int unsigned target;
    logic [15:0] crc;

    rst_n                  <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_index              <= RegSlaveAddr;
    cfg_wdata              <= 8'h00;
    in_ch.valid            <= 1'b0;
    in_ch.kind             <= KindStart;
    in_ch.register_address <= 16'h0000;
    in_ch.register_value   <= 16'h0000;
    in_ch.rx_byte          <= 8'h00;
    burst_left    = 0;
    counted_items = 0;
    hold_requests = 0;
    cur_slave     = 8'd1;
    cur_retry     = 4'd3;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // idle noise: ignored
    send_beat(KindByte, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
    send_beat(KindWinEnd, 16'h0000, 16'h0000, 8'h00, 1'b0);
    send_beat(KindUnused, 16'hFFFF, 16'h0000, 8'hFF, 1'b0);

    // long receiver hold while no-reply retries pile up to a failure
    hold_requests++;
    send_start(16'h0000, 16'hFFFF);
    send_win_end();
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(8'h00);
    send_win_end();
    send_win_end();

    // crc error retry, unused kind while busy, then a restart while busy
    send_start(16'h1234, 16'hA5C3);
    build_reply(ReplyBadCrc, 16'h1234, 16'hA5C3);
    foreach (reply_q[i]) send_rx(reply_q[i]);
    send_win_end();
    send_beat(KindUnused, 16'h0000, 16'hFFFF, 8'h00, 1'b0);
    send_start(16'h8001, 16'h7FFE);
    send_win_end();

    // resend after a slave address change, still inside the transaction
    quiesce();
    set_config(8'hFF, 4'd15);
    send_win_end();

    // reply longer than the buffer: the tail is neither counted nor crc'd
    addr = pick_word();
    val  = pick_word();
    send_start(addr, val);
    reply_q.delete();
    repeat (RxBufferBytes - 2) reply_q.push_back(8'($urandom));
    crc = CrcInit;
    foreach (reply_q[i]) crc = crc_byte(crc, reply_q[i]);
    reply_q.push_back(crc[7:0]);
    reply_q.push_back(crc[15:8]);
    repeat (6) reply_q.push_back(8'($urandom));
    foreach (reply_q[i]) send_rx(reply_q[i]);
    send_win_end();

    // random transactions over several register settings
    phase_slave = '{8'h00, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'h01};
    phase_retry = '{4'd1, 4'd0, 4'd2, 4'd15, 4'($urandom_range(1, 15)), 4'd3};
    counted_items = 0;
    for (int p = 0; p < NumPhases; p++) begin
      quiesce();
      set_config(phase_slave[p], phase_retry[p]);
      target = counted_items + RandomItems / NumPhases;
      while (counted_items < target) begin
        addr = pick_word();
        val  = pick_word();
        send_start(addr, val);
        limit     = (cur_retry == 4'd0) ? 4'd1 : cur_retry;
        abandoned = 1'b0;
        for (int att = 1; att <= limit; att++) begin
          if ($urandom_range(0, 11) == 0)
            send_beat(KindUnused, 16'($urandom), 16'($urandom), 8'($urandom), 1'b0);
          // drop the transaction and restart on the next pass
          if ($urandom_range(0, 19) == 0) begin
            abandoned = 1'b1;
            break;
          end
          case ($urandom_range(0, 9))
            0, 1, 2, 3: mode = ReplyEcho;
            4:          mode = ReplyLong;
            5, 6:       mode = ReplyBadCrc;
            7:          mode = ReplyShort;
            8:          mode = ReplyNone;
            default:    mode = ReplyGarbage;
          endcase
          build_reply(mode, addr, val);
          foreach (reply_q[i]) send_rx(reply_q[i]);
          send_win_end();
          if (mode == ReplyEcho || mode == ReplyLong) break;
        end
        // stray traffic after the transaction closed
        if (!abandoned && $urandom_range(0, 3) == 0) begin
          send_beat(KindByte, 16'($urandom), 16'($urandom), 8'($urandom), 1'b0);
          send_beat(KindWinEnd, 16'($urandom), 16'($urandom), 8'($urandom), 1'b0);
        end
      end
    end

    quiesce();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
